[src/frce_pkg.sv]
// Shared types and constants for the fuel rate and cut estimator.
package frce_pkg;

    localparam logic [21:0] RATE_MAX = 22'h3FFFFF;
    localparam logic [15:0] ECON_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_OFF  = 3'd1,
        SRC_ECU  = 3'd2,
        SRC_CUT  = 3'd3,
        SRC_AIR  = 3'd4
    } src_t;

    typedef enum logic [2:0] {
        REG_ENTER_RPM = 3'd0,
        REG_EXIT_RPM  = 3'd1,
        REG_CONFIRM   = 3'd2,
        REG_AIR_LIMIT = 3'd3,
        REG_MIXTURE   = 3'd4,
        REG_DENSITY   = 3'd5
    } reg_idx_t;

    // Restoring divider request, numerator and divisor both up to 48 bits.
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [47:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
        logic [47:0] rem;
    } div_rsp_t;

endpackage

[src/frce_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module frce_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  frce_pkg::div_req_t req,
    output frce_pkg::div_rsp_t rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [48:0] rem_reg, rem_next;
    logic [47:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[47:0], quo_reg[47]} - {1'b0, den_reg};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[48]) begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = {rem_reg[47:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start) den_reg <= req.den;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[47:0];

endmodule

[src/fuel_rate_and_cut_estimator_unit.sv]
// Top level of the fuel rate and fuel-cut estimator.
//
// Usage:
//  s_* : one engine sample per word (valid/ready). m_* : one result word per
//  sample. cfg_* : register writes (index, data), taken whenever offered;
//  write only while the block is idle.
//  A sample is decoded and the fuel-cut state updated in the cycle after
//  acceptance. The block then runs up to four divisions in turn on one
//  bit-serial divider: airflow rate, instant economy, fuel volume and
//  distance. ECU rate, fuel cut and a zero divisor skip the rate division;
//  invalid, engine-off and no-airflow samples skip all four. The result
//  word is loaded after the last division, or after decode if none ran.
//  One sample is in flight at a time; s_ready rises the cycle after the
//  result is loaded.
//  A stalled receiver holds the word in the output register; the next sample
//  is still taken, but its result is only loaded after the old word is taken.
//  Reset (aresetn low, synchronous) restores register defaults, clears the
//  cut flag, confirm timer and both remainders, and empties the output.
module fuel_rate_and_cut_estimator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_elapsed_ms,
    input  logic [3:0]  s_valid_mask,
    input  logic [13:0] s_engine_speed,
    input  logic [7:0]  s_vehicle_speed,
    input  logic signed [7:0] s_throttle_pct,
    input  logic signed [7:0] s_engine_load_pct,
    input  logic [7:0]  s_fuel_system_status,
    input  logic [15:0] s_airflow_x100,
    input  logic [15:0] s_mixture_ratio_x100,
    input  logic [21:0] s_ecu_fuel_rate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_estimate_valid,
    output logic        m_integrate_flag,
    output logic [2:0]  m_rate_source,
    output logic        m_low_speed_mode,
    output logic [21:0] m_fuel_rate_mlph,
    output logic [15:0] m_instant_economy_x100,
    output logic [21:0] m_fuel_microlitres,
    output logic [17:0] m_distance_millimetres,
    output logic [10:0] m_interval_ms
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DEC   = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_RATE  = 9'b000001000,
        ST_ECON  = 9'b000010000,
        ST_FUEL  = 9'b000100000,
        ST_DIST  = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [13:0] enter_rpm_reg, exit_rpm_reg;
    logic [15:0] confirm_reg, air_limit_reg;
    logic [11:0] mixture_reg;
    logic [9:0]  density_reg;

    // estimator state
    logic        cut_reg, cut_next;
    logic [15:0] timer_reg, timer_next;
    logic [11:0] fres_reg, fres_next;
    logic [4:0]  dres_reg, dres_next;

    // captured sample
    logic [11:0] dt_reg;
    logic [3:0]  mask_reg;
    logic [13:0] rpm_reg;
    logic [7:0]  spd_reg;
    logic signed [7:0] tps_reg, load_reg;
    logic [7:0]  status_reg;
    logic [15:0] maf_reg, afr_reg;
    logic [21:0] ecu_reg;

    // working values
    logic [21:0] rate_reg, rate_next;
    logic [15:0] econ_reg, econ_next;
    logic [21:0] fuel_reg, fuel_next;
    logic [17:0] dmm_reg, dmm_next;
    logic [2:0]  src_reg, src_next;
    logic        est_reg, est_next, integ_reg, integ_next;
    logic [21:0] div_den_reg, div_den_next;   // ratio * density
    logic [37:0] maf_mul_reg, maf_mul_next;   // maf * 3600000

    // output register
    logic        ov_reg;
    logic        o_est_reg, o_int_reg, o_low_reg;
    logic [2:0]  o_src_reg;
    logic [21:0] o_rate_reg, o_fuel_reg;
    logic [15:0] o_econ_reg;
    logic [17:0] o_dist_reg;
    logic [10:0] o_ivl_reg;

    frce_pkg::div_req_t dreq;
    frce_pkg::div_rsp_t drsp;

    frce_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // decode helpers
    logic bad, thr_closed, load_idle, load5, air_low, status4;
    logic [29:0] air_lhs, air_rhs;
    logic [15:0] timer_sum;
    logic [16:0] timer_add;
    logic [11:0] ratio;

    always_comb begin
        bad        = (dt_reg == 12'd0) || (dt_reg > 12'd2000) || !mask_reg[0] || !mask_reg[1];
        thr_closed = !tps_reg[7] && (tps_reg <= (cut_reg ? 8'sd18 : 8'sd16));
        load_idle  = !load_reg[7] && (load_reg <= 8'sd3);
        load5      = !load_reg[7] && (load_reg <= 8'sd5);
        status4    = status_reg == 8'd4;
        air_lhs    = 30'(maf_reg) * 30'd1000;
        air_rhs    = 30'(rpm_reg) * 30'(air_limit_reg);
        air_low    = mask_reg[2] && (rpm_reg != 14'd0) && (air_lhs <= air_rhs);
        timer_add  = {1'b0, timer_reg} + {5'd0, dt_reg};
        timer_sum  = timer_add[16] ? 16'hFFFF : timer_add[15:0];
        ratio      = (afr_reg >= 16'd800 && afr_reg <= 16'd2200) ? afr_reg[11:0] : mixture_reg;
    end

    always_comb begin
        state_next   = state_reg;
        cut_next     = cut_reg;
        timer_next   = timer_reg;
        fres_next    = fres_reg;
        dres_next    = dres_reg;
        rate_next    = rate_reg;
        econ_next    = econ_reg;
        fuel_next    = fuel_reg;
        dmm_next     = dmm_reg;
        src_next     = src_reg;
        est_next     = est_reg;
        integ_next   = integ_reg;
        div_den_next = div_den_reg;
        maf_mul_next = maf_mul_reg;
        dreq.start   = 1'b0;
        dreq.num     = '0;
        dreq.den     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DEC;
            end
            ST_DEC: begin
                rate_next  = '0;
                econ_next  = '0;
                fuel_next  = '0;
                dmm_next   = '0;
                src_next   = frce_pkg::SRC_NONE;
                est_next   = 1'b0;
                integ_next = 1'b0;
                state_next = ST_OUT;
                if (bad || rpm_reg == 14'd0) begin
                    cut_next   = 1'b0;
                    timer_next = '0;
                    if (!bad) begin
                        est_next = 1'b1;
                        src_next = frce_pkg::SRC_OFF;
                    end
                end else if (mask_reg[3]) begin
                    cut_next   = 1'b0;
                    timer_next = '0;
                    rate_next  = ecu_reg;
                    src_next   = frce_pkg::SRC_ECU;
                    est_next   = 1'b1;
                    integ_next = 1'b1;
                    state_next = ST_ECON;
                end else begin
                    if (cut_reg) begin
                        if (!(rpm_reg > exit_rpm_reg && spd_reg >= 8'd3) || !thr_closed ||
                            !((status4 && (air_low || load_idle)) || (load_idle && air_low) ||
                              (status_reg == 8'd0 && air_low && load5))) begin
                            cut_next   = 1'b0;
                            timer_next = '0;
                        end
                    end else if (!(rpm_reg >= enter_rpm_reg && spd_reg >= 8'd5) ||
                                 !((status4 && thr_closed && (air_low || load_idle)) ||
                                   (thr_closed && load_idle && air_low))) begin
                        timer_next = '0;
                    end else if (status4 && thr_closed && (air_low || load_idle)) begin
                        cut_next   = 1'b1;
                        timer_next = '0;
                    end else if (timer_sum >= confirm_reg) begin
                        cut_next   = 1'b1;
                        timer_next = '0;
                    end else begin
                        timer_next = timer_sum;
                    end
                    if (cut_next) begin
                        src_next   = frce_pkg::SRC_CUT;
                        est_next   = 1'b1;
                        integ_next = 1'b1;
                        state_next = ST_ECON;
                    end else if (mask_reg[2] && maf_reg != 16'd0) begin
                        src_next   = frce_pkg::SRC_AIR;
                        est_next   = 1'b1;
                        integ_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // two narrow multiplies, each into its own register
                div_den_next = 22'(ratio) * 22'(density_reg);
                maf_mul_next = 38'(maf_reg) * 38'd3600000;
                if (ratio == 12'd0 || density_reg == 10'd0) begin
                    rate_next  = frce_pkg::RATE_MAX;
                    state_next = ST_ECON;
                end else begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE: begin
                if (drsp.done) begin
                    rate_next  = (drsp.quo > 48'(frce_pkg::RATE_MAX)) ? frce_pkg::RATE_MAX
                                                                    : drsp.quo[21:0];
                    state_next = ST_ECON;
                end
            end
            ST_ECON: begin
                if (drsp.done) begin
                    econ_next  = (drsp.quo > 48'(frce_pkg::ECON_MAX)) ? frce_pkg::ECON_MAX
                                                                    : drsp.quo[15:0];
                    state_next = ST_FUEL;
                end
            end
            ST_FUEL: begin
                if (drsp.done) begin
                    fuel_next  = drsp.quo[21:0];
                    fres_next  = drsp.rem[11:0];
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                if (drsp.done) begin
                    dmm_next   = drsp.quo[17:0];
                    dres_next  = drsp.rem[4:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ov_reg || m_ready) state_next = ST_IDLE;
            end
            ST_WAIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase

        // divider launches on entry to each division state
        if (state_reg != ST_RATE && state_next == ST_RATE) begin
            dreq.start = 1'b1;
            dreq.num   = 48'(maf_mul_next);
            dreq.den   = 48'(div_den_next);
        end else if (state_reg != ST_ECON && state_next == ST_ECON) begin
            dreq.start = 1'b1;
            if (spd_reg < 8'd3) begin
                dreq.num = 48'(rate_next);
                dreq.den = 48'd10;
            end else begin
                dreq.num = 48'(26'(rate_next) * 26'd10);
                dreq.den = 48'(spd_reg);
            end
        end else if (state_reg != ST_FUEL && state_next == ST_FUEL) begin
            dreq.start = 1'b1;
            dreq.num   = 48'(34'(rate_reg) * 34'(dt_reg)) + 48'(fres_reg);
            dreq.den   = 48'd3600;
        end else if (state_reg != ST_DIST && state_next == ST_DIST) begin
            dreq.start = 1'b1;
            dreq.num   = 48'(23'(spd_reg) * 23'(dt_reg) * 23'd5) + 48'(dres_reg);
            dreq.den   = 48'd18;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enter_rpm_reg <= 14'd1050;
            exit_rpm_reg  <= 14'd950;
            confirm_reg   <= 16'd400;
            air_limit_reg <= 16'd500;
            mixture_reg   <= 12'd1470;
            density_reg   <= 10'd745;
            cut_reg       <= 1'b0;
            timer_reg     <= '0;
            fres_reg      <= '0;
            dres_reg      <= '0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            cut_reg   <= cut_next;
            timer_reg <= timer_next;
            fres_reg  <= fres_next;
            dres_reg  <= dres_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    frce_pkg::REG_ENTER_RPM: enter_rpm_reg <= cfg_data[13:0];
                    frce_pkg::REG_EXIT_RPM:  exit_rpm_reg  <= cfg_data[13:0];
                    frce_pkg::REG_CONFIRM:   confirm_reg   <= cfg_data;
                    frce_pkg::REG_AIR_LIMIT: air_limit_reg <= cfg_data;
                    frce_pkg::REG_MIXTURE:   mixture_reg   <= cfg_data[11:0];
                    frce_pkg::REG_DENSITY:   density_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!ov_reg || m_ready)) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
        if (state_reg == ST_IDLE && s_valid) begin
            dt_reg     <= s_elapsed_ms;
            mask_reg   <= s_valid_mask;
            rpm_reg    <= s_engine_speed;
            spd_reg    <= s_vehicle_speed;
            tps_reg    <= s_throttle_pct;
            load_reg   <= s_engine_load_pct;
            status_reg <= s_fuel_system_status;
            maf_reg    <= s_airflow_x100;
            afr_reg    <= s_mixture_ratio_x100;
            ecu_reg    <= s_ecu_fuel_rate;
        end
        rate_reg    <= rate_next;
        econ_reg    <= econ_next;
        fuel_reg    <= fuel_next;
        dmm_reg     <= dmm_next;
        src_reg     <= src_next;
        est_reg     <= est_next;
        integ_reg   <= integ_next;
        div_den_reg <= div_den_next;
        maf_mul_reg <= maf_mul_next;
        if (state_reg == ST_OUT && (!ov_reg || m_ready)) begin
            o_est_reg  <= est_reg;
            o_int_reg  <= integ_reg;
            o_src_reg  <= src_reg;
            o_low_reg  <= !bad && (spd_reg < 8'd3);
            o_rate_reg <= rate_reg;
            o_econ_reg <= econ_reg;
            o_fuel_reg <= fuel_reg;
            o_dist_reg <= dmm_reg;
            o_ivl_reg  <= integ_reg ? dt_reg[10:0] : 11'd0;
        end
    end

    assign m_valid                = ov_reg;
    assign m_estimate_valid       = o_est_reg;
    assign m_integrate_flag       = o_int_reg;
    assign m_rate_source          = o_src_reg;
    assign m_low_speed_mode       = o_low_reg;
    assign m_fuel_rate_mlph       = o_rate_reg;
    assign m_instant_economy_x100 = o_econ_reg;
    assign m_fuel_microlitres     = o_fuel_reg;
    assign m_distance_millimetres = o_dist_reg;
    assign m_interval_ms          = o_ivl_reg;

endmodule
